// ===== sv/trsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package trsc_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int RADIUS_W   = 31;
   localparam int CFG_W      = 17;
   localparam int BETA_W     = 17;
   localparam int FRAC_BITS  = 16;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ERR_W      = 51;
   localparam int MAG_W      = 49;
   localparam int LO_W       = 25;
   localparam int HI_W       = MAG_W - LO_W;
   localparam int ACC_W      = 100;
   localparam int R2_W       = 2 * RADIUS_W;
   localparam int REQ_DATA_W = 320;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_IDX_W  = 2;

   localparam logic [BETA_W-1:0] ONE_Q16      = BETA_W'(65536);
   localparam logic [CFG_W-1:0]  MAX_VERTICES = CFG_W'(65536);
   localparam logic [CFG_W-1:0]  FRACTION_RST = CFG_W'(32768);

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_UPDATE_FRACTION = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_R2,
      ST_R2_USE,
      ST_AXIS,
      ST_DECIDE,
      ST_SCALE,
      ST_THRESH,
      ST_DONE
   } trsc_state_type;

   typedef enum logic [1:0] {
      STG_FULL,
      STG_ZERO,
      STG_BITS
   } trsc_stage_type;

endpackage
`default_nettype wire

// ===== sv/trsc_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module trsc_mul
   import trsc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [MUL_W-1:0]  op_a,
   input  wire logic [MUL_W-1:0]  op_b,
   output logic      [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;

   // shared unsigned multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== sv/trust_region_step_clamp_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Trust-region step clamp, one vertex per item.
// req_ channel: a vertex (position, step, center, radius) in tdata, the
// unbounded flag in tuser and the last-vertex mark in tlast.
// rsp_ channel: the scaled step and beta in tdata, restricted and
// request_update in tuser, pass done in tlast. One result per item.
// csr_ channel: register writes (0 vertex_count, 1 update_fraction), taken
// any cycle; write only while no item is in flight.
// Every product goes through one shared 32x32 multiplier. A sphere test
// takes, per axis, one product for the error term and three for its
// square. An unbounded or zero step skips the sphere tests; an end point
// inside needs only the full test; a clamped step runs the full test, the
// zero test and, if the position lies inside, 16 bisection tests.
// req_tready is high only while the sequencer is idle. The result sits in
// an output register, so the next item is accepted while it waits; a
// stalled receiver holds the sequencer at the end of that next item.
// Reset clears the sequencer, the output valid, the restricted count and
// sets the registers to vertex_count 0 and update_fraction one half.
module trust_region_step_clamp_top
   import trsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // pos_x, pos_y, pos_z, step_x, step_y, step_z, center_x, center_y,
   // center_z, radius, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,   // radius_unbounded
   input  wire logic                  req_tlast,   // last_vertex
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // new_step_x, new_step_y, new_step_z, scale_ratio, zero fill
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [1:0]            rsp_tuser,   // restricted, request_update
   output logic                       rsp_tlast,   // pass_done
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_data
);

   trsc_state_type state_ff, state_in;
   trsc_stage_type stage_ff, stage_in;
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  axis_ff, axis_in;
   logic [3:0]  bit_ff, bit_in;
   logic [BETA_W-1:0] k_ff, k_in, beta_ff, beta_in;
   logic signed [DIFF_W-1:0]  d_ff [3];
   logic signed [COORD_W-1:0] s_ff [3];
   logic [RADIUS_W-1:0] radius_ff;
   logic last_ff;
   logic [R2_W-1:0]  r2_ff, r2_in;
   logic [MAG_W-1:0] em_ff, em_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [COORD_W-1:0] ns_ff [3];
   logic [COORD_W-1:0] ns_in [3];
   logic [CFG_W-1:0] count_ff, count_in;
   logic [CFG_W-1:0] vcount_ff, frac_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;
   logic rsp_last_ff, rsp_valid_ff;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;

   logic accept, out_free, in_sphere, zero_step, s_neg;
   logic [COORD_W-1:0] abs_s [3];
   logic signed [ERR_W-1:0] err, term;
   logic [ERR_W-1:0] err_mag;

   trsc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign zero_step = (req_tdata[COORD_W*6-1:COORD_W*3] == 96'd0);
   assign in_sphere = (acc_ff <= {{(ACC_W - R2_W - 32){1'b0}}, r2_ff, 32'd0});

   // step magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_s[i] = s_ff[i][COORD_W-1] ? COORD_W'(-s_ff[i]) : COORD_W'(s_ff[i]);
      end
   end

   // error term d*2^16 + s*k and its magnitude
   always_comb begin
      s_neg   = s_ff[axis_ff][COORD_W-1];
      term    = s_neg ? -$signed({2'b00, prod[48:0]}) : $signed({2'b00, prod[48:0]});
      err     = $signed({{2{d_ff[axis_ff][DIFF_W-1]}}, d_ff[axis_ff], 16'd0}) + term;
      err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   end

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         frac_ff   <= FRACTION_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_VERTEX_COUNT:    vcount_ff <= csr_data;
            REG_UPDATE_FRACTION: frac_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= $signed(req_tdata[COORD_W*(3+i) +: COORD_W]);
            d_ff[i] <= $signed({req_tdata[COORD_W*i + COORD_W-1], req_tdata[COORD_W*i +: COORD_W]})
                     - $signed({req_tdata[COORD_W*(6+i) + COORD_W-1],
                                req_tdata[COORD_W*(6+i) +: COORD_W]});
         end
         radius_ff <= req_tdata[COORD_W*9 +: RADIUS_W];
         last_ff   <= req_tlast;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= STG_FULL;
         phase_ff <= '0;
         axis_ff  <= '0;
         bit_ff   <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
         bit_ff   <= bit_in;
         count_ff <= count_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      beta_ff <= beta_in;
      r2_ff   <= r2_in;
      em_ff   <= em_in;
      acc_ff  <= acc_in;
      for (int i = 0; i < 3; i++) begin
         ns_ff[i] <= ns_in[i];
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {7'd0, beta_ff, ns_ff[2], ns_ff[1], ns_ff[0]};
         rsp_user_ff <= {last_ff && ({1'b0, count_ff, 16'd0} > prod[2*CFG_W-1:0]),
                         !beta_ff[BETA_W-1]};
         rsp_last_ff <= last_ff;
      end
   end

   // next state and multiplier operands
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      bit_in   = bit_ff;
      k_in     = k_ff;
      beta_in  = beta_ff;
      r2_in    = r2_ff;
      em_in    = em_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      for (int i = 0; i < 3; i++) begin
         ns_in[i] = ns_ff[i];
      end
      mul_a = MUL_W'(frac_ff);
      mul_b = MUL_W'(vcount_ff);
      case (state_ff)
         ST_IDLE: begin
            phase_in = '0;
            axis_in  = '0;
            acc_in   = '0;
            stage_in = STG_FULL;
            k_in     = ONE_Q16;
            beta_in  = ONE_Q16;
            if (accept) begin
               state_in = (req_tuser || zero_step) ? ST_SCALE : ST_R2;
            end
         end
         ST_R2: begin
            mul_a    = MUL_W'(radius_ff);
            mul_b    = MUL_W'(radius_ff);
            state_in = ST_R2_USE;
         end
         ST_R2_USE: begin
            r2_in    = prod[R2_W-1:0];
            state_in = ST_AXIS;
         end
         ST_AXIS: begin
            case (phase_ff)
               3'd0: begin
                  mul_a    = abs_s[axis_ff];
                  mul_b    = MUL_W'(k_ff);
                  phase_in = 3'd1;
               end
               3'd1: begin
                  em_in    = err_mag[MAG_W-1:0];
                  phase_in = 3'd2;
               end
               3'd2: begin
                  mul_a    = MUL_W'(em_ff[LO_W-1:0]);
                  mul_b    = MUL_W'(em_ff[LO_W-1:0]);
                  phase_in = 3'd3;
               end
               3'd3: begin
                  acc_in   = acc_ff + ACC_W'(prod);
                  mul_a    = MUL_W'(em_ff[MAG_W-1:LO_W]);
                  mul_b    = MUL_W'(em_ff[LO_W-1:0]);
                  phase_in = 3'd4;
               end
               3'd4: begin
                  acc_in   = acc_ff + (ACC_W'(prod) << (LO_W + 1));
                  mul_a    = MUL_W'(em_ff[MAG_W-1:LO_W]);
                  mul_b    = MUL_W'(em_ff[MAG_W-1:LO_W]);
                  phase_in = 3'd5;
               end
               default: begin
                  acc_in   = acc_ff + (ACC_W'(prod) << (2 * LO_W));
                  phase_in = '0;
                  if (axis_ff == 2'd2) begin
                     axis_in  = '0;
                     state_in = ST_DECIDE;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_DECIDE: begin
            acc_in   = '0;
            state_in = ST_AXIS;
            case (stage_ff)
               STG_FULL: begin
                  if (in_sphere) begin
                     beta_in  = ONE_Q16;
                     state_in = ST_SCALE;
                  end else begin
                     stage_in = STG_ZERO;
                     k_in     = '0;
                  end
               end
               STG_ZERO: begin
                  beta_in = '0;
                  if (!in_sphere) begin
                     state_in = ST_SCALE;
                  end else begin
                     stage_in = STG_BITS;
                     bit_in   = 4'd15;
                     k_in     = BETA_W'(32768);
                  end
               end
               default: begin
                  beta_in = in_sphere ? k_ff : beta_ff;
                  if (bit_ff == 4'd0) begin
                     state_in = ST_SCALE;
                  end else begin
                     bit_in = bit_ff - 4'd1;
                     k_in   = beta_in | (BETA_W'(1) << (bit_ff - 4'd1));
                  end
               end
            endcase
         end
         ST_SCALE: begin
            // one axis product per cycle, stored from the multiplier output in the next cycle
            if (phase_ff != 3'd0) begin
               ns_in[phase_ff[1:0] - 2'd1] =
                  s_ff[phase_ff[1:0] - 2'd1][COORD_W-1] ? COORD_W'(-prod[47:16])
                                                          : prod[47:16];
            end
            if (phase_ff == 3'd3) begin
               phase_in = '0;
               state_in = ST_THRESH;
            end else begin
               mul_a    = abs_s[phase_ff[1:0]];
               mul_b    = MUL_W'(beta_ff);
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_THRESH: begin
            if (!beta_ff[BETA_W-1] && count_ff < MAX_VERTICES) begin
               count_in = count_ff + CFG_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               if (last_ff) begin
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire
